/* rtl/core/cpt_pkg.sv */
`default_nettype none
package cpt_pkg;

  localparam int CW     = 24;           // coordinate width
  localparam int FB     = 20;           // fraction bits
  localparam int EW     = CW + 1;       // vertex difference width
  localparam int PW     = 2 * EW;       // difference product width
  localparam int DW     = PW + 2;       // dot product width
  localparam int HW     = DW / 2;       // low half for split multiply
  localparam int VW     = 2 * DW + 4;   // cross term / divider width
  localparam int WW     = FB + 1;       // weight width
  localparam int BW     = EW + WW + 2;  // blend accumulator width
  localparam int IN_DW  = ((12 * CW + 7) / 8) * 8;
  localparam int OUT_USED = 3 * CW + 3 * WW + 3;
  localparam int OUT_DW = ((OUT_USED + 7) / 8) * 8;

  localparam logic [WW-1:0] ONE = {1'b1, {FB{1'b0}}};

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [EW-1:0] dif_t;
  typedef crd_t [2:0]           cvec_t;
  typedef dif_t [2:0]           dvec_t;
  typedef logic signed [PW-1:0] pr_t;
  typedef logic signed [DW-1:0] dot_t;
  typedef logic signed [VW-1:0] vw_t;
  typedef logic [WW-1:0]        wgt_t;
  typedef logic signed [BW-1:0] bl_t;

  typedef enum logic [2:0] {
    REG_VA   = 3'd0,
    REG_VB   = 3'd1,
    REG_EAB  = 3'd2,
    REG_VC   = 3'd3,
    REG_EAC  = 3'd4,
    REG_EBC  = 3'd5,
    REG_FACE = 3'd6
  } region_t;

  // carried alongside the divider
  typedef struct packed {
    region_t region;
    cvec_t   base;
    dvec_t   e1;
    dvec_t   e2;
  } div_pay_t;

  function automatic logic le0(vw_t x);
    return x[VW-1] | (x == '0);
  endfunction

  function automatic logic neg(vw_t x);
    return x[VW-1];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/cpt_div.sv */
`default_nettype none
module cpt_div import cpt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  vw_t      in_n1,
  input  vw_t      in_n2,
  input  vw_t      in_den,
  input  div_pay_t in_pay,
  output logic     out_valid,
  input  logic     out_ready,
  output wgt_t     out_q1,
  output wgt_t     out_q2,
  output div_pay_t out_pay
);

  logic [FB:0]    v;
  logic [FB:0]    en;
  logic [VW-1:0]  dd [0:FB];
  logic [VW-1:0]  r1 [0:FB];
  logic [VW-1:0]  r2 [0:FB];
  logic [FB-1:0]  b1 [0:FB];
  logic [FB-1:0]  b2 [0:FB];
  logic [FB:0]    f1;
  logic [FB:0]    f2;
  div_pay_t       pay [0:FB];

  logic [VW-1:0]  t1 [1:FB];
  logic [VW-1:0]  t2 [1:FB];
  logic [FB:1]    c1;
  logic [FB:1]    c2;

  logic signed [VW:0] df1, df2;
  logic z1, z2, full1, full2;

  always_comb begin
    en[FB] = !v[FB] || out_ready;
    for (int k = FB - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k <= FB; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // clamp: n <= 0 gives 0, n >= d gives 1.0, else long division
  always_comb begin
    df1   = {in_n1[VW-1], in_n1} - {in_den[VW-1], in_den};
    df2   = {in_n2[VW-1], in_n2} - {in_den[VW-1], in_den};
    z1    = le0(in_n1);
    z2    = le0(in_n2);
    full1 = !z1 && !df1[VW];
    full2 = !z2 && !df2[VW];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dd[0]  <= in_den;
      r1[0]  <= (z1 || full1) ? '0 : in_n1;
      r2[0]  <= (z2 || full2) ? '0 : in_n2;
      b1[0]  <= '0;
      b2[0]  <= '0;
      f1[0]  <= full1;
      f2[0]  <= full2;
      pay[0] <= in_pay;
    end
  end

  // one quotient bit per stage
  for (genvar g = 1; g <= FB; g++) begin : g_step
    assign t1[g] = {r1[g-1][VW-2:0], 1'b0};
    assign t2[g] = {r2[g-1][VW-2:0], 1'b0};
    assign c1[g] = t1[g] >= dd[g-1];
    assign c2[g] = t2[g] >= dd[g-1];

    always_ff @(posedge clk) begin
      if (en[g]) begin
        r1[g]  <= c1[g] ? t1[g] - dd[g-1] : t1[g];
        r2[g]  <= c2[g] ? t2[g] - dd[g-1] : t2[g];
        b1[g]  <= {b1[g-1][FB-2:0], c1[g]};
        b2[g]  <= {b2[g-1][FB-2:0], c2[g]};
        f1[g]  <= f1[g-1];
        f2[g]  <= f2[g-1];
        dd[g]  <= dd[g-1];
        pay[g] <= pay[g-1];
      end
    end
  end

  assign out_valid = v[FB];
  assign out_q1    = f1[FB] ? ONE : {1'b0, b1[FB]};
  assign out_q2    = f2[FB] ? ONE : {1'b0, b2[FB]};
  assign out_pay   = pay[FB];

endmodule
`default_nettype wire

/* rtl/core/closest_point_on_triangle_top.sv */
// Closest point on a triangle to a query point, 3-D, signed Q3.20.
// Input stream s_*: one word = query point and three vertices.
// Output stream m_*: one word = closest point, barycentric weights
// (unsigned Q1.20) and the region code (vertex, edge or interior).
// Both sides use tvalid/tready; a word moves when both are high.
// The pipeline has 31 register stages. Throughput: one word per
// cycle while m_tready is high. Every stage has its own valid bit
// and moves when it is empty or the stage after it moves, so bubbles
// are squeezed out and input is still taken while a finished result
// waits at the output.
// Stages: differences, products, dot sums, split cross products (two
// stages), cross terms, face denominator, region select, 21-stage
// restoring divider pair (a clamp stage, then one quotient bit per
// stage), blend multiply, round/saturate into the output register.
// Reset (rst, synchronous) empties the pipeline; nothing else is kept.
// When m_tready is low the output word holds; upstream stages keep
// filling until the pipeline is full, then s_tready drops.
// A degenerate triangle (zero divisor) returns vertex a, region 0.
`default_nettype none
module closest_point_on_triangle_top import cpt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // point x,y,z, a x,y,z, b x,y,z, c x,y,z (24 bits each, low first)
  input  logic [IN_DW-1:0]  s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // near x,y,z (24), weight a,b,c (21), region (3), zero pad
  output logic [OUT_DW-1:0] m_tdata
);

  logic [8:1] v;
  logic [8:1] en;
  logic       div_ready;

  // ready chain, front section
  always_comb begin
    en[8] = !v[8] || div_ready;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_tvalid;
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // unpack input word
  cvec_t in_p, in_a, in_b, in_c;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_p[k] = s_tdata[k*CW +: CW];
      in_a[k] = s_tdata[(3+k)*CW +: CW];
      in_b[k] = s_tdata[(6+k)*CW +: CW];
      in_c[k] = s_tdata[(9+k)*CW +: CW];
    end
  end

  // s1: edge and offset vectors
  cvec_t s1_a, s1_b, s1_c;
  dvec_t s1_ab, s1_ac, s1_ap, s1_bp, s1_cp, s1_cb;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_a <= in_a;
      s1_b <= in_b;
      s1_c <= in_c;
      for (int k = 0; k < 3; k++) begin
        s1_ab[k] <= dif_t'(in_b[k]) - dif_t'(in_a[k]);
        s1_ac[k] <= dif_t'(in_c[k]) - dif_t'(in_a[k]);
        s1_ap[k] <= dif_t'(in_p[k]) - dif_t'(in_a[k]);
        s1_bp[k] <= dif_t'(in_p[k]) - dif_t'(in_b[k]);
        s1_cp[k] <= dif_t'(in_p[k]) - dif_t'(in_c[k]);
        s1_cb[k] <= dif_t'(in_c[k]) - dif_t'(in_b[k]);
      end
    end
  end

  // s2: per-axis products of the six dot products
  cvec_t s2_a, s2_b, s2_c;
  dvec_t s2_ab, s2_ac, s2_cb;
  pr_t   s2_pr [0:5][0:2];
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_a  <= s1_a;
      s2_b  <= s1_b;
      s2_c  <= s1_c;
      s2_ab <= s1_ab;
      s2_ac <= s1_ac;
      s2_cb <= s1_cb;
      for (int k = 0; k < 3; k++) begin
        s2_pr[0][k] <= s1_ab[k] * s1_ap[k];
        s2_pr[1][k] <= s1_ac[k] * s1_ap[k];
        s2_pr[2][k] <= s1_ab[k] * s1_bp[k];
        s2_pr[3][k] <= s1_ac[k] * s1_bp[k];
        s2_pr[4][k] <= s1_ab[k] * s1_cp[k];
        s2_pr[5][k] <= s1_ac[k] * s1_cp[k];
      end
    end
  end

  // s3: d1..d6
  cvec_t s3_a, s3_b, s3_c;
  dvec_t s3_ab, s3_ac, s3_cb;
  dot_t  s3_d [0:5];
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_a  <= s2_a;
      s3_b  <= s2_b;
      s3_c  <= s2_c;
      s3_ab <= s2_ab;
      s3_ac <= s2_ac;
      s3_cb <= s2_cb;
      for (int j = 0; j < 6; j++) begin
        s3_d[j] <= dot_t'(s2_pr[j][0]) + dot_t'(s2_pr[j][1]) + dot_t'(s2_pr[j][2]);
      end
    end
  end

  // s4: cross products d*d split into half-width partials
  // order: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  dot_t mx [0:5];
  dot_t my [0:5];
  always_comb begin
    mx[0] = s3_d[0]; my[0] = s3_d[3];
    mx[1] = s3_d[2]; my[1] = s3_d[1];
    mx[2] = s3_d[4]; my[2] = s3_d[1];
    mx[3] = s3_d[0]; my[3] = s3_d[5];
    mx[4] = s3_d[2]; my[4] = s3_d[5];
    mx[5] = s3_d[4]; my[5] = s3_d[3];
  end

  cvec_t s4_a, s4_b, s4_c;
  dvec_t s4_ab, s4_ac, s4_cb;
  dot_t  s4_d [0:5];
  logic signed [2*(DW-HW)-1:0] s4_hh [0:5];
  logic signed [2*(DW-HW):0]   s4_hl [0:5];
  logic signed [2*(DW-HW):0]   s4_lh [0:5];
  logic [2*HW-1:0]             s4_ll [0:5];
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_a  <= s3_a;
      s4_b  <= s3_b;
      s4_c  <= s3_c;
      s4_ab <= s3_ab;
      s4_ac <= s3_ac;
      s4_cb <= s3_cb;
      s4_d  <= s3_d;
      for (int j = 0; j < 6; j++) begin
        s4_hh[j] <= $signed(mx[j][DW-1:HW]) * $signed(my[j][DW-1:HW]);
        s4_hl[j] <= $signed(mx[j][DW-1:HW]) * $signed({1'b0, my[j][HW-1:0]});
        s4_lh[j] <= $signed({1'b0, mx[j][HW-1:0]}) * $signed(my[j][DW-1:HW]);
        s4_ll[j] <= mx[j][HW-1:0] * my[j][HW-1:0];
      end
    end
  end

  // s5: recombine partials
  cvec_t s5_a, s5_b, s5_c;
  dvec_t s5_ab, s5_ac, s5_cb;
  dot_t  s5_d [0:5];
  vw_t   s5_wp [0:5];
  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_a  <= s4_a;
      s5_b  <= s4_b;
      s5_c  <= s4_c;
      s5_ab <= s4_ab;
      s5_ac <= s4_ac;
      s5_cb <= s4_cb;
      s5_d  <= s4_d;
      for (int j = 0; j < 6; j++) begin
        s5_wp[j] <= (vw_t'(s4_hh[j]) <<< (2 * HW))
                  + ((vw_t'(s4_hl[j]) + vw_t'(s4_lh[j])) <<< HW)
                  + vw_t'(s4_ll[j]);
      end
    end
  end

  // s6: area terms and edge denominators
  cvec_t s6_a, s6_b, s6_c;
  dvec_t s6_ab, s6_ac, s6_cb;
  vw_t   s6_d1, s6_d2, s6_d3, s6_d6;
  vw_t   s6_va, s6_vb, s6_vc, s6_e43, s6_e56, s6_dab, s6_dac;
  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_a   <= s5_a;
      s6_b   <= s5_b;
      s6_c   <= s5_c;
      s6_ab  <= s5_ab;
      s6_ac  <= s5_ac;
      s6_cb  <= s5_cb;
      s6_d1  <= vw_t'(s5_d[0]);
      s6_d2  <= vw_t'(s5_d[1]);
      s6_d3  <= vw_t'(s5_d[2]);
      s6_d6  <= vw_t'(s5_d[5]);
      s6_vc  <= s5_wp[0] - s5_wp[1];
      s6_vb  <= s5_wp[2] - s5_wp[3];
      s6_va  <= s5_wp[4] - s5_wp[5];
      s6_e43 <= vw_t'(s5_d[3]) - vw_t'(s5_d[2]);
      s6_e56 <= vw_t'(s5_d[4]) - vw_t'(s5_d[5]);
      s6_dab <= vw_t'(s5_d[0]) - vw_t'(s5_d[2]);
      s6_dac <= vw_t'(s5_d[1]) - vw_t'(s5_d[5]);
    end
  end

  // s7: face and bc denominators
  cvec_t s7_a, s7_b, s7_c;
  dvec_t s7_ab, s7_ac, s7_cb;
  vw_t   s7_d1, s7_d2, s7_d3, s7_d6;
  vw_t   s7_va, s7_vb, s7_vc, s7_e43, s7_e56, s7_dab, s7_dac, s7_dbc, s7_df;
  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_a   <= s6_a;
      s7_b   <= s6_b;
      s7_c   <= s6_c;
      s7_ab  <= s6_ab;
      s7_ac  <= s6_ac;
      s7_cb  <= s6_cb;
      s7_d1  <= s6_d1;
      s7_d2  <= s6_d2;
      s7_d3  <= s6_d3;
      s7_d6  <= s6_d6;
      s7_va  <= s6_va;
      s7_vb  <= s6_vb;
      s7_vc  <= s6_vc;
      s7_e43 <= s6_e43;
      s7_e56 <= s6_e56;
      s7_dab <= s6_dab;
      s7_dac <= s6_dac;
      s7_dbc <= s6_e43 + s6_e56;
      s7_df  <= s6_va + s6_vb + s6_vc;
    end
  end

  // region select; vertex and fallback cases use zero edge vectors
  div_pay_t c_pay;
  vw_t      c_n1, c_n2, c_den;
  always_comb begin
    c_pay.region = REG_VA;
    c_pay.base   = s7_a;
    c_pay.e1     = '0;
    c_pay.e2     = '0;
    c_n1         = '0;
    c_n2         = '0;
    c_den        = vw_t'(1);
    if (le0(s7_d1) && le0(s7_d2)) begin
      c_pay.region = REG_VA;
    end else if (!neg(s7_d3) && le0(s7_e43)) begin
      c_pay.region = REG_VB;
      c_pay.base   = s7_b;
    end else if (le0(s7_vc) && !neg(s7_d1) && le0(s7_d3)) begin
      if (!le0(s7_dab)) begin
        c_pay.region = REG_EAB;
        c_pay.e1     = s7_ab;
        c_n1         = s7_d1;
        c_den        = s7_dab;
      end
    end else if (!neg(s7_d6) && le0(s7_e56)) begin
      c_pay.region = REG_VC;
      c_pay.base   = s7_c;
    end else if (le0(s7_vb) && !neg(s7_d2) && le0(s7_d6)) begin
      if (!le0(s7_dac)) begin
        c_pay.region = REG_EAC;
        c_pay.e1     = s7_ac;
        c_n1         = s7_d2;
        c_den        = s7_dac;
      end
    end else if (le0(s7_va) && !neg(s7_e43) && !neg(s7_e56)) begin
      if (!le0(s7_dbc)) begin
        c_pay.region = REG_EBC;
        c_pay.base   = s7_b;
        c_pay.e1     = s7_cb;
        c_n1         = s7_e43;
        c_den        = s7_dbc;
      end
    end else if (!le0(s7_df)) begin
      c_pay.region = REG_FACE;
      c_pay.e1     = s7_ab;
      c_pay.e2     = s7_ac;
      c_n1         = s7_vb;
      c_n2         = s7_vc;
      c_den        = s7_df;
    end
  end

  // s8: divider operands
  div_pay_t s8_pay;
  vw_t      s8_n1, s8_n2, s8_den;
  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_pay <= c_pay;
      s8_n1  <= c_n1;
      s8_n2  <= c_n2;
      s8_den <= c_den;
    end
  end

  logic     dv_valid;
  logic     t1_en;
  wgt_t     dv_q1, dv_q2;
  div_pay_t dv_pay;

  cpt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[8]),
    .in_ready  (div_ready),
    .in_n1     (s8_n1),
    .in_n2     (s8_n2),
    .in_den    (s8_den),
    .in_pay    (s8_pay),
    .out_valid (dv_valid),
    .out_ready (t1_en),
    .out_q1    (dv_q1),
    .out_q2    (dv_q2),
    .out_pay   (dv_pay)
  );

  // tail: blend multiply, then round/saturate into the output register
  logic    t1_v, o_v, o_en;
  region_t t1_region;
  cvec_t   t1_base;
  wgt_t    t1_q1, t1_q2;
  bl_t     t1_pa [0:2];
  bl_t     t1_pb [0:2];

  assign o_en  = !o_v || m_tready;
  assign t1_en = !t1_v || o_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
      o_v  <= 1'b0;
    end else begin
      if (t1_en) t1_v <= dv_valid;
      if (o_en)  o_v  <= t1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (t1_en) begin
      t1_region <= dv_pay.region;
      t1_base   <= dv_pay.base;
      t1_q1     <= dv_q1;
      t1_q2     <= dv_q2;
      for (int k = 0; k < 3; k++) begin
        t1_pa[k] <= dv_pay.e1[k] * $signed({1'b0, dv_q1});
        t1_pb[k] <= dv_pay.e2[k] * $signed({1'b0, dv_q2});
      end
    end
  end

  localparam bl_t RND  = bl_t'(1) <<< (FB - 1);
  localparam bl_t CMAX = {{(BW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam bl_t CMIN = ~CMAX;

  bl_t           acc [0:2];
  bl_t           pos [0:2];
  cvec_t         c_near;
  logic [WW:0]   qsum;
  wgt_t          c_wa, c_wb, c_wc;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = t1_pa[k] + t1_pb[k] + RND;
      pos[k] = (acc[k] >>> FB) + bl_t'(t1_base[k]);
      if (pos[k] > CMAX) begin
        c_near[k] = CMAX[CW-1:0];
      end else if (pos[k] < CMIN) begin
        c_near[k] = CMIN[CW-1:0];
      end else begin
        c_near[k] = pos[k][CW-1:0];
      end
    end
    qsum = {1'b0, t1_q1} + {1'b0, t1_q2};
    case (t1_region)
      REG_VB: begin
        c_wa = '0; c_wb = ONE; c_wc = '0;
      end
      REG_VC: begin
        c_wa = '0; c_wb = '0; c_wc = ONE;
      end
      REG_EAB: begin
        c_wa = ONE - t1_q1; c_wb = t1_q1; c_wc = '0;
      end
      REG_EAC: begin
        c_wa = ONE - t1_q1; c_wb = '0; c_wc = t1_q1;
      end
      REG_EBC: begin
        c_wa = '0; c_wb = ONE - t1_q1; c_wc = t1_q1;
      end
      REG_FACE: begin
        c_wa = (qsum >= {1'b0, ONE}) ? '0 : ONE - t1_q1 - t1_q2;
        c_wb = t1_q1;
        c_wc = t1_q2;
      end
      default: begin
        c_wa = ONE; c_wb = '0; c_wc = '0;
      end
    endcase
  end

  cvec_t   o_near;
  wgt_t    o_wa, o_wb, o_wc;
  region_t o_region;
  always_ff @(posedge clk) begin
    if (o_en) begin
      o_near   <= c_near;
      o_wa     <= c_wa;
      o_wb     <= c_wb;
      o_wc     <= c_wc;
      o_region <= t1_region;
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = {{(OUT_DW-OUT_USED){1'b0}}, o_region, o_wc, o_wb, o_wa,
                     o_near[2], o_near[1], o_near[0]};

`ifndef SYNTHESIS
  // outside the face case the weights always sum to exactly 1.0
  a_wsum: assert property (@(posedge clk) disable iff (rst)
    (o_v && o_region != REG_FACE) |->
      ({2'b0, o_wa} + {2'b0, o_wb} + {2'b0, o_wc} == {2'b0, ONE}))
    else $error("weights do not sum to one");

  // an empty first stage must always take input
  a_bubble: assert property (@(posedge clk) disable iff (rst)
    !v[1] |-> s_tready)
    else $error("input stalled with empty first stage");

  // divider quotients never exceed 1.0
  a_qrange: assert property (@(posedge clk) disable iff (rst)
    t1_v |-> (t1_q1 <= ONE && t1_q2 <= ONE))
    else $error("quotient out of range");

  // a held output word is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (o_v && !m_tready) |=> (o_v && $stable(o_near) && $stable(o_region)))
    else $error("stalled output changed");
`endif

endmodule
`default_nettype wire
